FILE: rtl/mpht_pkg.sv
package mpht_pkg;

  typedef struct packed {
    logic        opcode;
    logic [63:0] hash_value;
    logic [63:0] key;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  target_rank;
    logic [7:0]  bucket_index;
    logic [63:0] read_data;
  } out_item_t;

  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EVICT = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  localparam logic [2:0] REG_RANK_COUNT  = 3'd0;
  localparam logic [2:0] REG_BUCKETS     = 3'd1;
  localparam logic [2:0] REG_PROBE_COUNT = 3'd2;
  localparam logic [2:0] REG_SLICE_SHIFT = 3'd3;
  localparam logic [2:0] REG_RANK_SHIFT  = 3'd4;

  // Divider request and response between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [8:0] remainder;
  } div_rsp_t;

endpackage

FILE: rtl/mpht_divider.sv
// Restoring remainder unit: one dividend bit per cycle.
module mpht_divider (
  input  logic              clk,
  input  logic              rst,
  input  mpht_pkg::div_req_t req,
  output mpht_pkg::div_rsp_t rsp
);

  logic [63:0] dvd;
  logic [8:0]  dvs;
  logic [9:0]  rem;
  logic [6:0]  cnt;
  logic        busy;
  logic        done_r;
  logic [9:0]  shifted;
  logic [9:0]  diff;

  always_comb begin
    shifted = {rem[8:0], dvd[63]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[62:0], 1'b0};
        rem <= diff[9] ? shifted : diff;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = {done_r, rem[8:0]};

endmodule

FILE: rtl/mpht_store.sv
// Bucket store: used bit, key and data in one memory.
// After reset a clearing pass zeroes every slot, one per cycle.
module mpht_store #(
  parameter int SLOTS = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] addr,
  input  logic          wr,
  input  logic [63:0]   wr_key,
  input  logic [63:0]   wr_data,
  output logic          clearing,
  output logic          rd_used,
  output logic [63:0]   rd_key,
  output logic [63:0]   rd_data
);

  logic [128:0]  mem [SLOTS];
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] waddr;
  logic [128:0]  wword;
  logic          wen;

  // Clearing pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(SLOTS - 1)) clearing <= 1'b0;
    end
  end

  always_comb begin
    wen   = clearing || wr;
    waddr = clearing ? clr_addr : addr;
    wword = clearing ? 129'd0 : {1'b1, wr_key, wr_data};
  end

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wword;
    {rd_used, rd_key, rd_data} <= mem[addr];
  end

endmodule

FILE: rtl/multi_probe_hash_table_top.sv
// Channel | Direction | Handshake    | Payload
// in      | input     | valid/stall  | opcode, hash_value, key, write_data
// out     | output    | valid/stall  | status, target_rank, bucket_index, read_data
// cfg     | input     | valid/ready  | index, data (5 registers)
//
// Each of the clamped probe_count + 1 modulo reductions runs on the shared
// bit-serial divider; each bucket probe is a read then a check on the single
// memory port, and a write adds a memory write before the result is loaded.
// Reset (rst, synchronous) restores register defaults, then a clearing pass
// over all 1024 slots keeps in_stall high while it runs.
// in_stall is high while an item is worked and while a result is held stalled.
module multi_probe_hash_table_top #(
  parameter int MAX_RANKS  = 4,
  parameter int BUCKETS    = 256,
  parameter int MAX_PROBES = 8,
  parameter int KEY_BITS   = 64,
  parameter int DATA_BITS  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpht_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mpht_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW    = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int PW    = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int SLOTS = MAX_RANKS * BUCKETS;
  localparam int AW    = $clog2(SLOTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SLICE = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_CHK   = 7'b0010000,
    S_WR    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [2:0] rank_count;
  logic [8:0] buckets_in_use;
  logic [3:0] probe_count;
  logic [5:0] slice_shift;
  logic [5:0] rank_shift_amount;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_count        <= 3'd1;
      buckets_in_use    <= 9'd256;
      probe_count       <= 4'd1;
      slice_shift       <= 6'd0;
      rank_shift_amount <= 6'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mpht_pkg::REG_RANK_COUNT:  rank_count        <= cfg_data[2:0];
        mpht_pkg::REG_BUCKETS:     buckets_in_use    <= cfg_data[8:0];
        mpht_pkg::REG_PROBE_COUNT: probe_count       <= cfg_data[3:0];
        mpht_pkg::REG_SLICE_SHIFT: slice_shift       <= cfg_data[5:0];
        mpht_pkg::REG_RANK_SHIFT:  rank_shift_amount <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Clamped divisors and counts
  logic [8:0] ranks_c, nbuck_c;
  logic [3:0] probes_c;
  logic [6:0] width;
  logic [63:0] smask;
  always_comb begin
    ranks_c = (rank_count == 3'd0) ? 9'd1 :
              (32'(rank_count) > MAX_RANKS) ? 9'(MAX_RANKS) : {6'd0, rank_count};
    nbuck_c = (buckets_in_use == 9'd0) ? 9'd1 :
              (32'(buckets_in_use) > BUCKETS) ? 9'(BUCKETS) : buckets_in_use;
    probes_c = (probe_count == 4'd0) ? 4'd1 :
               (32'(probe_count) > MAX_PROBES) ? 4'(MAX_PROBES) : probe_count;
    width = {(4'd9 - probes_c), 3'b000};
    smask = (width > 7'd32) ? 64'hFFFF_FFFF : ((64'd1 << width) - 64'd1);
  end

  mpht_pkg::in_item_t item;
  logic [BW-1:0] cand [MAX_PROBES];
  logic [RW-1:0] rank;
  logic [3:0]    idx;       // probe being worked; MAX_PROBES marks the rank
  logic [9:0]    pos;
  logic [63:0]   hash_sh;
  mpht_pkg::div_req_t dreq;
  mpht_pkg::div_rsp_t drsp;

  mpht_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Next dividend: slice or shifted hash
  logic [63:0] slice;
  always_comb begin
    slice = (pos >= 10'd64) ? 64'd0 : ((item.hash_value >> pos[5:0]) & smask);
    slice = (slice_shift >= 6'd32) ? 64'd0 : (slice >> slice_shift);
    hash_sh = item.hash_value >> rank_shift_amount;
  end

  logic [AW-1:0] addr;
  logic          mwr;
  logic          clearing;
  logic          rd_used;
  logic [63:0]   rd_key, rd_data;
  logic [63:0]   key_m, data_m;
  logic [3:0]    pi;

  assign key_m  = item.key & ((KEY_BITS >= 64) ? ~64'd0 : ((64'd1 << KEY_BITS) - 64'd1));
  assign data_m = item.write_data &
                  ((DATA_BITS >= 64) ? ~64'd0 : ((64'd1 << DATA_BITS) - 64'd1));
  assign addr = AW'(32'(rank) * BUCKETS + 32'(cand[pi[PW-1:0]]));
  assign mwr  = (state == S_WR);

  mpht_store #(.SLOTS(SLOTS), .AW(AW)) u_store (
    .clk(clk), .rst(rst), .addr(addr), .wr(mwr), .wr_key(key_m), .wr_data(data_m),
    .clearing(clearing), .rd_used(rd_used), .rd_key(rd_key), .rd_data(rd_data)
  );

  logic [1:0] status;
  logic [63:0] rdata;
  logic [7:0]  bidx;
  logic        load_out;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall) || clearing;
  assign dreq = {(state == S_SLICE),
                 (idx == 4'(MAX_PROBES)) ? hash_sh : slice,
                 (idx == 4'(MAX_PROBES)) ? ranks_c : nbuck_c};
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      pi        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item  <= in_data;
            idx   <= 4'd0;
            pos   <= 10'd0;
            state <= S_SLICE;
          end
        end
        S_SLICE: state <= S_DIV;
        S_DIV: begin
          if (drsp.done) begin
            if (idx == 4'(MAX_PROBES)) begin
              rank  <= RW'(drsp.remainder);
              pi    <= 4'd0;
              state <= S_RD;
            end else begin
              cand[idx[PW-1:0]] <= BW'(drsp.remainder);
              pos <= pos + 10'(width);
              if (idx + 4'd1 == probes_c) idx <= 4'(MAX_PROBES);
              else idx <= idx + 4'd1;
              state <= S_SLICE;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (item.opcode == mpht_pkg::OP_WRITE) begin
            if (!rd_used || rd_key == key_m) begin
              status <= mpht_pkg::ST_OK;
              state  <= S_WR;
            end else if (pi + 4'd1 == probes_c) begin
              status <= mpht_pkg::ST_EVICT;
              state  <= S_WR;
            end else begin
              pi    <= pi + 4'd1;
              state <= S_RD;
            end
          end else begin
            if (rd_used && rd_key == key_m) begin
              status <= mpht_pkg::ST_OK;
              bidx   <= 8'(cand[pi[PW-1:0]]);
              rdata  <= rd_data;
              state  <= S_OUT;
            end else if (!rd_used || pi + 4'd1 == probes_c) begin
              status <= mpht_pkg::ST_MISS;
              bidx   <= 8'd0;
              rdata  <= 64'd0;
              state  <= S_OUT;
            end else begin
              pi    <= pi + 4'd1;
              state <= S_RD;
            end
          end
        end
        S_WR: begin
          bidx  <= 8'(cand[pi[PW-1:0]]);
          rdata <= 64'd0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.status       <= status;
      out_data.target_rank  <= 2'(rank);
      out_data.bucket_index <= bidx;
      out_data.read_data    <= rdata;
    end
  end

  // A result never appears while a stalled one is held
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result overwritten while stalled");

  // Memory writes only after a probe check
  assert property (@(posedge clk) disable iff (rst)
    mwr |-> $past(state) == S_CHK)
    else $error("write without probe");

  // Input accepted only from idle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> state == S_IDLE)
    else $error("accept outside idle");

endmodule
